// ===== rtl/css_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_pkg
// Shared constants and types for the schedule simulator.
// ----------------------------------------------------------------------------
package css_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int TIME_W = 21;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_SJF  = 2'd1;
    localparam logic [1:0] MODE_PRIO = 2'd2;
    localparam logic [1:0] MODE_RR   = 2'd3;

    localparam logic [0:0] REG_MODE    = 1'b0;
    localparam logic [0:0] REG_QUANTUM = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;        // store input word at load count
        logic sched_init;  // clear time, completed count, done flags
        logic scan_clr;    // start a new scan pass
        logic scan_step;   // examine entry at scan index
        logic scan_commit; // act on scan result
        logic out_clr;     // reset output index
        logic out_read;    // issue read of output entry
        logic out_cap;     // capture output word
        logic clear;       // clear load state after results
    } css_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic scan_end;    // scan index on last loaded entry
        logic all_done;
        logic out_last;    // output index on last loaded entry
        logic empty;       // no entry loaded
    } css_sts_t;

endpackage

// ===== rtl/cpu_schedule_simulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_schedule_simulator
// Loads a process set and simulates FCFS, SJF, priority or round robin.
// Loading: one word per cycle while in_stall is low. After the last word,
// serial scan passes over the N loaded entries run until all are done;
// results then stream one word at a time, each read and then captured.
// Reset: async, active low; clears counts, flags, time and control state.
// ----------------------------------------------------------------------------
module cpu_schedule_simulator
    import css_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [15:0]       arrival_time,
    input  logic [15:0]       burst_time,
    input  logic [7:0]        priority_level,
    input  logic              last_process,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [4:0]        process_number,
    output logic [TIME_W-1:0] completion_time,
    output logic [TIME_W-1:0] turnaround_time,
    output logic [TIME_W-1:0] waiting_time,
    output logic              last_result
);

    logic [1:0]  mode_reg;
    logic [15:0] quantum_reg;
    css_cmd_t    cmd;
    css_sts_t    sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_FCFS;
            quantum_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[1:0];
                REG_QUANTUM: quantum_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    css_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .last_process (last_process),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    css_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .mode            (mode_reg),
        .quantum         (quantum_reg),
        .arrival_time    (arrival_time),
        .burst_time      (burst_time),
        .priority_level  (priority_level),
        .process_number  (process_number),
        .completion_time (completion_time),
        .turnaround_time (turnaround_time),
        .waiting_time    (waiting_time),
        .last_result     (last_result)
    );

endmodule

// ===== rtl/css_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_datapath
// Process store, scan unit, time keeping and result formatting.
// ----------------------------------------------------------------------------
module css_datapath
    import css_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  css_cmd_t            cmd,
    output css_sts_t            sts,
    input  logic [1:0]          mode,
    input  logic [15:0]         quantum,
    input  logic [15:0]         arrival_time,
    input  logic [15:0]         burst_time,
    input  logic [7:0]          priority_level,
    output logic [4:0]          process_number,
    output logic [TIME_W-1:0]   completion_time,
    output logic [TIME_W-1:0]   turnaround_time,
    output logic [TIME_W-1:0]   waiting_time,
    output logic                last_result
);

    logic [15:0]       arr_mem [MAX_PROCS];
    logic [15:0]       bur_mem [MAX_PROCS];
    logic [7:0]        pri_mem [MAX_PROCS];
    logic [15:0]       rem_mem [MAX_PROCS];
    logic [TIME_W-1:0] ct_mem  [MAX_PROCS];
    logic [MAX_PROCS-1:0] done_reg;

    logic [CNT_W-1:0]  loaded_reg;
    logic [CNT_W-1:0]  completed_reg;
    logic [TIME_W-1:0] time_reg;
    logic [IDX_W-1:0]  scan_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic              found_reg;
    logic [15:0]       best_reg;
    logic [16:0]       earliest_reg;
    logic              ran_reg;
    logic [IDX_W-1:0]  oidx_reg;

    logic [15:0] bur_in;
    logic [15:0] key;
    logic        pend;
    logic        ready;
    logic [15:0] rem_cur;
    logic [15:0] slice;
    logic [15:0] q;
    logic [TIME_W-1:0] start_t;

    assign bur_in = (burst_time == 16'd0) ? 16'd1 : burst_time;
    assign q      = (quantum == 16'd0) ? 16'd1 : quantum;
    assign pend   = !done_reg[scan_reg];
    assign ready  = pend && ({5'd0, arr_mem[scan_reg]} <= time_reg);
    assign key    = (mode == MODE_PRIO) ? {8'd0, pri_mem[scan_reg]} : bur_mem[scan_reg];
    assign rem_cur = rem_mem[scan_reg];
    assign slice  = (rem_cur < q) ? rem_cur : q;
    assign start_t = ({5'd0, arr_mem[scan_reg]} > time_reg) ?
                     {5'd0, arr_mem[scan_reg]} : time_reg;

    assign sts.full     = (loaded_reg == CNT_W'(MAX_PROCS));
    assign sts.scan_end = ({1'b0, scan_reg} == CNT_W'(loaded_reg - 1'b1));
    assign sts.all_done = (completed_reg == loaded_reg);
    assign sts.out_last = ({1'b0, oidx_reg} == CNT_W'(loaded_reg - 1'b1));
    assign sts.empty    = (loaded_reg == '0);

    // store writes
    always_ff @(posedge clk)
    begin
        if (cmd.load && !sts.full)
        begin
            arr_mem[loaded_reg[IDX_W-1:0]] <= arrival_time;
            bur_mem[loaded_reg[IDX_W-1:0]] <= bur_in;
            pri_mem[loaded_reg[IDX_W-1:0]] <= priority_level;
            rem_mem[loaded_reg[IDX_W-1:0]] <= bur_in;
        end
        else if (cmd.scan_step && mode == MODE_FCFS)
        begin
            ct_mem[scan_reg] <= start_t + TIME_W'(bur_mem[scan_reg]);
        end
        else if (cmd.scan_step && mode == MODE_RR && ready)
        begin
            rem_mem[scan_reg] <= rem_cur - slice;
            if (rem_cur == slice)
                ct_mem[scan_reg] <= time_reg + TIME_W'(slice);
        end
        else if (cmd.scan_commit && mode != MODE_RR && mode != MODE_FCFS && found_reg)
        begin
            ct_mem[pick_reg] <= time_reg + TIME_W'(bur_mem[pick_reg]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            completed_reg <= '0;
            time_reg      <= '0;
            done_reg      <= '0;
            scan_reg      <= '0;
            pick_reg      <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '1;
            earliest_reg  <= '1;
            ran_reg       <= 1'b0;
            oidx_reg      <= '0;
        end
        else
        begin
            if (cmd.load && !sts.full)
                loaded_reg <= loaded_reg + 1'b1;
            if (cmd.sched_init)
            begin
                time_reg      <= '0;
                completed_reg <= '0;
                done_reg      <= '0;
            end
            if (cmd.scan_clr)
            begin
                scan_reg     <= '0;
                found_reg    <= 1'b0;
                best_reg     <= '1;
                earliest_reg <= '1;
                ran_reg      <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (!sts.scan_end)
                    scan_reg <= scan_reg + 1'b1;
                if (pend && {1'b0, arr_mem[scan_reg]} < earliest_reg)
                    earliest_reg <= {1'b0, arr_mem[scan_reg]};
                case (mode)
                    MODE_FCFS:
                    begin
                        time_reg <= start_t + TIME_W'(bur_mem[scan_reg]);
                        done_reg[scan_reg] <= 1'b1;
                        completed_reg <= completed_reg + 1'b1;
                    end
                    MODE_RR:
                    begin
                        if (ready)
                        begin
                            time_reg <= time_reg + TIME_W'(slice);
                            ran_reg  <= 1'b1;
                            if (rem_cur == slice)
                            begin
                                done_reg[scan_reg] <= 1'b1;
                                completed_reg <= completed_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (ready && (!found_reg || key < best_reg))
                        begin
                            best_reg  <= key;
                            pick_reg  <= scan_reg;
                            found_reg <= 1'b1;
                        end
                    end
                endcase
            end
            if (cmd.scan_commit)
            begin
                if (mode == MODE_RR)
                begin
                    if (!ran_reg)
                        time_reg <= TIME_W'(earliest_reg);
                end
                else if (mode != MODE_FCFS)
                begin
                    if (found_reg)
                    begin
                        time_reg <= time_reg + TIME_W'(bur_mem[pick_reg]);
                        done_reg[pick_reg] <= 1'b1;
                        completed_reg <= completed_reg + 1'b1;
                    end
                    else
                        time_reg <= TIME_W'(earliest_reg);
                end
            end
            if (cmd.out_clr)
                oidx_reg <= '0;
            else if (cmd.out_cap && !sts.out_last)
                oidx_reg <= oidx_reg + 1'b1;
            if (cmd.clear)
            begin
                loaded_reg    <= '0;
                completed_reg <= '0;
                time_reg      <= '0;
                done_reg      <= '0;
            end
        end
    end

    // registered read of the output entry, then format
    logic [TIME_W-1:0] ct_rd_reg;
    logic [15:0]       arr_rd_reg;
    logic [15:0]       bur_rd_reg;
    logic [IDX_W-1:0]  idx_rd_reg;
    logic              last_rd_reg;
    logic [TIME_W-1:0] tat;

    always_ff @(posedge clk)
    begin
        if (cmd.out_read)
        begin
            ct_rd_reg   <= ct_mem[oidx_reg];
            arr_rd_reg  <= arr_mem[oidx_reg];
            bur_rd_reg  <= bur_mem[oidx_reg];
            idx_rd_reg  <= oidx_reg;
            last_rd_reg <= sts.out_last;
        end
    end

    assign tat = ct_rd_reg - TIME_W'(arr_rd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_cap)
        begin
            process_number  <= 5'({1'b0, idx_rd_reg} + 1'b1);
            completion_time <= ct_rd_reg;
            turnaround_time <= tat;
            waiting_time    <= tat - TIME_W'(bur_rd_reg);
            last_result     <= last_rd_reg;
        end
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        completed_reg <= loaded_reg)
        else $error("completed count above loaded count");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && !sts.full |=> loaded_reg == $past(loaded_reg) + 1'b1)
        else $error("load did not advance count");
    a_clr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> loaded_reg == '0 && done_reg == '0)
        else $error("clear left state");
`endif

endmodule

// ===== rtl/css_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_ctrl
// Sequencer: load, scan passes, result streaming.
// ----------------------------------------------------------------------------
module css_ctrl
    import css_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic     last_process,
    output logic     out_valid,
    input  logic     out_stall,
    output css_cmd_t cmd,
    input  css_sts_t sts
);

    typedef enum logic [2:0] {
        S_LOAD, S_INIT, S_SCAN, S_COMMIT, S_ORD, S_OCAP, S_OWAIT
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   accept;

    assign in_stall  = (state_reg != S_LOAD);
    assign out_valid = ov_reg;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ov_next    = ov_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.load = accept;
                if (accept && last_process)
                begin
                    cmd.sched_init = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.scan_clr = 1'b1;
                cmd.out_clr  = 1'b1;
                if (sts.empty || sts.all_done)
                    state_next = sts.empty ? S_LOAD : S_ORD;
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_end)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.scan_commit = 1'b1;
                state_next = S_INIT;
            end
            S_ORD:
            begin
                cmd.out_read = 1'b1;
                state_next = S_OCAP;
            end
            S_OCAP:
            begin
                if (!ov_reg || !out_stall)
                begin
                    cmd.out_cap = 1'b1;
                    ov_next = 1'b1;
                    if (sts.out_last)
                    begin
                        cmd.clear = 1'b1;
                        state_next = S_OWAIT;
                    end
                    else
                        state_next = S_ORD;
                end
            end
            S_OWAIT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
        if (state_reg != S_OCAP && state_reg != S_OWAIT && ov_reg && !out_stall)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

`ifndef SYNTHESIS
    a_ov: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OWAIT |-> ov_reg)
        else $error("drain state without word");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg)
        else $error("stalled word dropped");
    a_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> !sts.empty)
        else $error("scan with empty store");
`endif

endmodule
